### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, codes and control types of the sorted priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 32;
  localparam int PRIO_W  = 16;
  localparam int ENTRY_W = 6;
  localparam int STAT_W  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } spq_cmd_t;

endpackage

### hw/rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: captures a transaction, then runs it once the
// result register can take the outcome
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output spq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign slot_free   = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.execute = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.execute) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// sorted cell array with parallel compare and shift, plus result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_datapath
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_cmd_t                  cmd,
  input  logic                      in_opcode,
  input  logic signed [VAL_W-1:0]   in_element_value,
  input  logic signed [PRIO_W-1:0]  in_element_priority,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VAL_W-1:0]   out_removed_value,
  output logic signed [PRIO_W-1:0]  out_removed_priority,
  output logic [ENTRY_W-1:0]        out_entry_count
);

  logic                     op_r;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [PRIO_W-1:0] prio_r;

  logic [CNT_W-1:0] count_r, count_nxt;

  logic signed [VAL_W-1:0]  val_cell_r  [DEPTH];
  logic signed [PRIO_W-1:0] prio_cell_r [DEPTH];
  logic signed [VAL_W-1:0]  val_cell_nxt  [DEPTH];
  logic signed [PRIO_W-1:0] prio_cell_nxt [DEPTH];
  logic signed [VAL_W-1:0]  val_up   [DEPTH];
  logic signed [PRIO_W-1:0] prio_up  [DEPTH];
  logic signed [VAL_W-1:0]  val_dn   [DEPTH];
  logic signed [PRIO_W-1:0] prio_dn  [DEPTH];

  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] from_prev;
  logic             full, empty;

  logic [STAT_W-1:0]        status_r, status_nxt;
  logic signed [VAL_W-1:0]  rval_r, rval_nxt;
  logic signed [PRIO_W-1:0] rprio_r, rprio_nxt;
  logic [ENTRY_W-1:0]       rcount_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // occupied cells whose priority is below the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (prio_cell_r[i] < prio_r);
    end
  end

  assign from_prev = {lt[DEPTH-2:0], 1'b0};

  // neighbor views for shifting
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      val_up[i]  = val_cell_r[i+1];
      prio_up[i] = prio_cell_r[i+1];
    end
    val_up[DEPTH-1]  = val_cell_r[DEPTH-1];
    prio_up[DEPTH-1] = prio_cell_r[DEPTH-1];
    val_dn[0]  = val_cell_r[0];
    prio_dn[0] = prio_cell_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      val_dn[i]  = val_cell_r[i-1];
      prio_dn[i] = prio_cell_r[i-1];
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    rval_nxt   = '0;
    rprio_nxt  = '0;
    count_nxt  = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      val_cell_nxt[i]  = val_cell_r[i];
      prio_cell_nxt[i] = prio_cell_r[i];
    end
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (from_prev[i]) begin
              val_cell_nxt[i]  = val_dn[i];
              prio_cell_nxt[i] = prio_dn[i];
            end else if ((CNT_W'(i) == count_r) || lt[i]) begin
              val_cell_nxt[i]  = val_r;
              prio_cell_nxt[i] = prio_r;
            end
          end
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          rval_nxt  = val_cell_r[0];
          rprio_nxt = prio_cell_r[0];
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            val_cell_nxt[i]  = val_up[i];
            prio_cell_nxt[i] = prio_up[i];
          end
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // captured transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_opcode;
      val_r  <= in_element_value;
      prio_r <= in_element_priority;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        val_cell_r[i]  <= val_cell_nxt[i];
        prio_cell_r[i] <= prio_cell_nxt[i];
      end
      status_r <= status_nxt;
      rval_r   <= rval_nxt;
      rprio_r  <= rprio_nxt;
      rcount_r <= ENTRY_W'(count_nxt);
    end
  end

  assign out_status           = status_r;
  assign out_removed_value    = rval_r;
  assign out_removed_priority = rprio_r;
  assign out_entry_count      = rcount_r;

endmodule

### hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue kept sorted, highest priority first
// timing: result registered in the execute step after the input transaction
//   is accepted, held back while an earlier result still waits on out_ready
// flow: a new transaction waits until the previous one has run, set by the
//   capture and execute steps of the controller; all cells update at once
// reset: synchronous active-low rst_n empties the queue and the result slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic signed [VAL_W-1:0]   in_element_value,
  input  logic signed [PRIO_W-1:0]  in_element_priority,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VAL_W-1:0]   out_removed_value,
  output logic signed [PRIO_W-1:0]  out_removed_priority,
  output logic [ENTRY_W-1:0]        out_entry_count
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .in_opcode            (in_opcode),
    .in_element_value     (in_element_value),
    .in_element_priority  (in_element_priority),
    .out_status           (out_status),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority),
    .out_entry_count      (out_entry_count)
  );

endmodule
